// File: hdl/mid_pkg.sv
// shared types and constants for the minimum image displacement block
package mid_pkg;

    localparam int LEN_W      = 32;
    localparam int PROD_W     = 64;
    localparam int FRAC_W     = 66;
    localparam int FRAC_SHIFT = 46;
    localparam int CNT_W      = 20;
    localparam int TRANS_W    = 54;
    localparam int N_STAGES   = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_CELL_AX_BX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_CX_BY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_CY_CZ  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECIP_AX_BX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RECIP_CX_BY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RECIP_CY_CZ = 3'd5;

    typedef logic signed [LEN_W-1:0] len_t;
    typedef logic signed [CNT_W-1:0] cnt_t;
    typedef logic [N_STAGES-1:0] stage_load_t;

    // upper-triangular cell, Q16.16
    typedef struct packed {
        len_t ax;
        len_t bx;
        len_t cx;
        len_t by;
        len_t cy;
        len_t cz;
    } cell_t;

    // non-zero reciprocal entries, Q2.30
    typedef struct packed {
        len_t rax;
        len_t ray;
        len_t raz;
        len_t rby;
        len_t rbz;
        len_t rcz;
    } recip_t;

    typedef struct packed {
        len_t dx;
        len_t dy;
        len_t dz;
    } vec_t;

    typedef struct packed {
        cnt_t na;
        cnt_t nb;
        cnt_t nc;
    } shift_t;

endpackage

// File: hdl/mid_cfg.sv
// configuration register file holding cell and reciprocal entries
module mid_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mid_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mid_pkg::CFG_DATA_W-1:0]   cfg_data,
    output mid_pkg::cell_t                   lattice,
    output mid_pkg::recip_t                  recip
);

    logic [mid_pkg::CFG_DATA_W-1:0] cell_ax_bx_reg;
    logic [mid_pkg::CFG_DATA_W-1:0] cell_cx_by_reg;
    logic [mid_pkg::CFG_DATA_W-1:0] cell_cy_cz_reg;
    logic [mid_pkg::CFG_DATA_W-1:0] recip_ax_bx_reg;
    logic [mid_pkg::CFG_DATA_W-1:0] recip_cx_by_reg;
    logic [mid_pkg::CFG_DATA_W-1:0] recip_cy_cz_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_ax_bx_reg  <= '0;
            cell_cx_by_reg  <= '0;
            cell_cy_cz_reg  <= '0;
            recip_ax_bx_reg <= '0;
            recip_cx_by_reg <= '0;
            recip_cy_cz_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mid_pkg::REG_CELL_AX_BX:  cell_ax_bx_reg  <= cfg_data;
                mid_pkg::REG_CELL_CX_BY:  cell_cx_by_reg  <= cfg_data;
                mid_pkg::REG_CELL_CY_CZ:  cell_cy_cz_reg  <= cfg_data;
                mid_pkg::REG_RECIP_AX_BX: recip_ax_bx_reg <= cfg_data;
                mid_pkg::REG_RECIP_CX_BY: recip_cx_by_reg <= cfg_data;
                mid_pkg::REG_RECIP_CY_CZ: recip_cy_cz_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        lattice.ax = cell_ax_bx_reg[63:32];
        lattice.bx = cell_ax_bx_reg[31:0];
        lattice.cx = cell_cx_by_reg[63:32];
        lattice.by = cell_cx_by_reg[31:0];
        lattice.cy = cell_cy_cz_reg[63:32];
        lattice.cz = cell_cy_cz_reg[31:0];
        recip.rax  = recip_ax_bx_reg[63:32];
        recip.ray  = recip_ax_bx_reg[31:0];
        recip.raz  = recip_cx_by_reg[63:32];
        recip.rby  = recip_cx_by_reg[31:0];
        recip.rbz  = recip_cy_cz_reg[63:32];
        recip.rcz  = recip_cy_cz_reg[31:0];
    end

endmodule

// File: hdl/mid_frac.sv
// stages 1 to 3: fractional coordinates and rounding to lattice counts
module mid_frac (
    input  logic              clk,
    input  logic [2:0]        load,
    input  mid_pkg::recip_t   recip,
    input  mid_pkg::vec_t     delta,
    output mid_pkg::vec_t     delta_aligned,
    output mid_pkg::shift_t   shift
);

    localparam logic [mid_pkg::FRAC_W-1:0] HALF_UNIT =
        mid_pkg::FRAC_W'(1) << (mid_pkg::FRAC_SHIFT - 1);

    typedef logic signed [mid_pkg::PROD_W-1:0] prod_t;
    typedef logic signed [mid_pkg::FRAC_W-1:0] frac_t;

    // halves go away from zero
    function automatic mid_pkg::cnt_t round_half_away(input frac_t s);
        logic [mid_pkg::FRAC_W-1:0] mag;
        logic [mid_pkg::FRAC_W-1:0] biased;
        logic [mid_pkg::CNT_W-1:0]  q;
        mag    = s[mid_pkg::FRAC_W-1] ? mid_pkg::FRAC_W'(-s) : mid_pkg::FRAC_W'(s);
        biased = mag + HALF_UNIT;
        q      = biased[mid_pkg::FRAC_SHIFT +: mid_pkg::CNT_W];
        return s[mid_pkg::FRAC_W-1] ? -$signed(q) : $signed(q);
    endfunction

    // stage 1: products
    mid_pkg::vec_t d1_reg;
    prod_t p_ax_reg, p_ay_reg, p_az_reg, p_by_reg, p_bz_reg, p_cz_reg;
    // stage 2: sums
    mid_pkg::vec_t d2_reg;
    frac_t s_a_reg, s_b_reg, s_c_reg;
    frac_t s_a_next, s_b_next, s_c_next;
    // stage 3: rounded counts
    mid_pkg::vec_t  d3_reg;
    mid_pkg::shift_t n_reg, n_next;

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            d1_reg   <= delta;
            p_ax_reg <= mid_pkg::PROD_W'(recip.rax) * mid_pkg::PROD_W'(delta.dx);
            p_ay_reg <= mid_pkg::PROD_W'(recip.ray) * mid_pkg::PROD_W'(delta.dy);
            p_az_reg <= mid_pkg::PROD_W'(recip.raz) * mid_pkg::PROD_W'(delta.dz);
            p_by_reg <= mid_pkg::PROD_W'(recip.rby) * mid_pkg::PROD_W'(delta.dy);
            p_bz_reg <= mid_pkg::PROD_W'(recip.rbz) * mid_pkg::PROD_W'(delta.dz);
            p_cz_reg <= mid_pkg::PROD_W'(recip.rcz) * mid_pkg::PROD_W'(delta.dz);
        end
    end

    always_comb
    begin
        s_a_next = mid_pkg::FRAC_W'(p_ax_reg) + mid_pkg::FRAC_W'(p_ay_reg)
                 + mid_pkg::FRAC_W'(p_az_reg);
        s_b_next = mid_pkg::FRAC_W'(p_by_reg) + mid_pkg::FRAC_W'(p_bz_reg);
        s_c_next = mid_pkg::FRAC_W'(p_cz_reg);
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            d2_reg  <= d1_reg;
            s_a_reg <= s_a_next;
            s_b_reg <= s_b_next;
            s_c_reg <= s_c_next;
        end
    end

    always_comb
    begin
        n_next.na = round_half_away(s_a_reg);
        n_next.nb = round_half_away(s_b_reg);
        n_next.nc = round_half_away(s_c_reg);
    end

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            d3_reg <= d2_reg;
            n_reg  <= n_next;
        end
    end

    assign delta_aligned = d3_reg;
    assign shift         = n_reg;

endmodule

// File: hdl/mid_wrap.sv
// stages 4 and 5: lattice translation, subtraction and saturation
module mid_wrap (
    input  logic              clk,
    input  logic [1:0]        load,
    input  mid_pkg::cell_t    lattice,
    input  mid_pkg::vec_t     delta,
    input  mid_pkg::shift_t   shift,
    output mid_pkg::vec_t     wrapped
);

    typedef logic signed [mid_pkg::TRANS_W-1:0] trans_t;

    localparam trans_t SAT_MAX = mid_pkg::TRANS_W'(32'sh7FFF_FFFF);
    localparam trans_t SAT_MIN = mid_pkg::TRANS_W'(32'sh8000_0000);

    function automatic mid_pkg::len_t sat_len(input trans_t v);
        trans_t c;
        c = v;
        if (v > SAT_MAX)
        begin
            c = SAT_MAX;
        end
        else if (v < SAT_MIN)
        begin
            c = SAT_MIN;
        end
        return c[mid_pkg::LEN_W-1:0];
    endfunction

    mid_pkg::vec_t d4_reg;
    trans_t t_ax_reg, t_bx_reg, t_cx_reg, t_by_reg, t_cy_reg, t_cz_reg;
    mid_pkg::vec_t out_reg, out_next;

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            d4_reg   <= delta;
            t_ax_reg <= mid_pkg::TRANS_W'(lattice.ax) * mid_pkg::TRANS_W'(shift.na);
            t_bx_reg <= mid_pkg::TRANS_W'(lattice.bx) * mid_pkg::TRANS_W'(shift.nb);
            t_cx_reg <= mid_pkg::TRANS_W'(lattice.cx) * mid_pkg::TRANS_W'(shift.nc);
            t_by_reg <= mid_pkg::TRANS_W'(lattice.by) * mid_pkg::TRANS_W'(shift.nb);
            t_cy_reg <= mid_pkg::TRANS_W'(lattice.cy) * mid_pkg::TRANS_W'(shift.nc);
            t_cz_reg <= mid_pkg::TRANS_W'(lattice.cz) * mid_pkg::TRANS_W'(shift.nc);
        end
    end

    always_comb
    begin
        out_next.dx = sat_len(mid_pkg::TRANS_W'(d4_reg.dx)
                              - (t_ax_reg + t_bx_reg + t_cx_reg));
        out_next.dy = sat_len(mid_pkg::TRANS_W'(d4_reg.dy) - (t_by_reg + t_cy_reg));
        out_next.dz = sat_len(mid_pkg::TRANS_W'(d4_reg.dz) - t_cz_reg);
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            out_reg <= out_next;
        end
    end

    assign wrapped = out_reg;

endmodule

// File: hdl/minimum_image_displacement.sv
// throughput: one beat per cycle while the output is not stalled; stages, in order, are
// products, fraction sums, rounding, translation products, subtract and saturate,
// at most one multiplier deep each
// each stage advances on its own when empty, so bubbles fill under output stall
// reset clears all stage valid bits and loads zero into every configuration register
module minimum_image_displacement (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [31:0]               delta_x,
    input  logic signed [31:0]               delta_y,
    input  logic signed [31:0]               delta_z,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [31:0]               wrapped_x,
    output logic signed [31:0]               wrapped_y,
    output logic signed [31:0]               wrapped_z,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mid_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mid_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int NS = mid_pkg::N_STAGES;

    mid_pkg::stage_load_t valid_reg, valid_next, load;
    mid_pkg::cell_t       lattice;
    mid_pkg::recip_t      recip;
    mid_pkg::vec_t        delta, delta_mid, wrapped;
    mid_pkg::shift_t      shift;

    // a stage loads when it is empty or its successor loads
    always_comb
    begin
        load[NS-1] = !valid_reg[NS-1] || !out_stall;
        for (int i = NS - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
        valid_next[0] = load[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NS; i++)
        begin
            valid_next[i] = load[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !load[0];
    assign out_valid = valid_reg[NS-1];

    assign delta.dx = delta_x;
    assign delta.dy = delta_y;
    assign delta.dz = delta_z;

    mid_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .lattice   (lattice),
        .recip     (recip)
    );

    mid_frac u_frac (
        .clk           (clk),
        .load          (load[2:0]),
        .recip         (recip),
        .delta         (delta),
        .delta_aligned (delta_mid),
        .shift         (shift)
    );

    mid_wrap u_wrap (
        .clk     (clk),
        .load    (load[4:3]),
        .lattice (lattice),
        .delta   (delta_mid),
        .shift   (shift),
        .wrapped (wrapped)
    );

    assign wrapped_x = wrapped.dx;
    assign wrapped_y = wrapped.dy;
    assign wrapped_z = wrapped.dz;

endmodule

// File: hdl/mid_chk.sv
// port-level checker for the minimum image displacement block and its bind
module mid_chk (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic signed [31:0]  delta_x,
    input logic signed [31:0]  delta_y,
    input logic signed [31:0]  delta_z,
    input logic                out_valid,
    input logic                out_stall,
    input logic signed [31:0]  wrapped_x,
    input logic signed [31:0]  wrapped_y,
    input logic signed [31:0]  wrapped_z,
    input logic                cfg_valid,
    input logic                cfg_ready,
    input logic [2:0]          cfg_index,
    input logic [63:0]         cfg_data
);

    // input backs up only when the whole pipe is full behind a stalled output
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output side can drain");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(wrapped_x)
                                   && $stable(wrapped_y) && $stable(wrapped_z))
        else $error("stalled output beat changed or dropped");

    // a fresh output beat after an empty slot must trace back to an accepted input beat
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 5))
        else $error("output beat without matching input beat");

endmodule

bind minimum_image_displacement mid_chk u_mid_chk (.*);

// File: dv/minimum_image_displacement_tb.sv
// self-checking testbench for the triclinic minimum image displacement block
module minimum_image_displacement_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD       = 80;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int MAX_REPORTS     = 10;

    // indexes past the register list, writes there must be dropped
    localparam logic [mid_pkg::CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
    localparam logic [mid_pkg::CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

    localparam mid_pkg::len_t MAX_LEN   = 32'sh7fff_ffff;
    localparam mid_pkg::len_t MIN_LEN   = 32'sh8000_0000;
    localparam mid_pkg::len_t FOUR_LEN  = 32'sh0004_0000;
    localparam mid_pkg::len_t EIGHT_LEN = 32'sh0008_0000;

    // holds the cell, predicts wrapped vectors and checks them in order
    class wrap_board;
        logic [mid_pkg::CFG_DATA_W-1:0] regs [6];
        mid_pkg::vec_t expected_q [$];
        int   mismatches;

        // registers come out of reset as zero
        function new();
            foreach (regs[i])
                regs[i] = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [mid_pkg::CFG_IDX_W-1:0] idx,
                              logic [mid_pkg::CFG_DATA_W-1:0] data);
            if (idx <= mid_pkg::REG_RECIP_CY_CZ)
                regs[idx] = data;
        endfunction

        function logic signed [67:0] prod(mid_pkg::len_t a, mid_pkg::len_t b);
            return longint'(a) * longint'(b);
        endfunction

        // fraction carries 46 fractional bits, halves round away from zero
        function longint round_frac(logic signed [67:0] f);
            logic [67:0] mag;
            mag = (f < 0) ? -f : f;
            mag = (mag + (68'd1 << 45)) >> mid_pkg::FRAC_SHIFT;
            return (f < 0) ? -longint'(mag) : longint'(mag);
        endfunction

        function mid_pkg::len_t sat(longint v);
            if (v > 64'sd2147483647)
                return MAX_LEN;
            if (v < -64'sd2147483648)
                return MIN_LEN;
            return mid_pkg::len_t'(v);
        endfunction

        function mid_pkg::vec_t predict_wrap(mid_pkg::vec_t d);
            mid_pkg::len_t ax, bx, cx, by, cy, cz, rax, ray, raz, rby, rbz, rcz;
            longint        na, nb, nc;
            mid_pkg::vec_t w;
            ax  = regs[mid_pkg::REG_CELL_AX_BX][63:32];
            bx  = regs[mid_pkg::REG_CELL_AX_BX][31:0];
            cx  = regs[mid_pkg::REG_CELL_CX_BY][63:32];
            by  = regs[mid_pkg::REG_CELL_CX_BY][31:0];
            cy  = regs[mid_pkg::REG_CELL_CY_CZ][63:32];
            cz  = regs[mid_pkg::REG_CELL_CY_CZ][31:0];
            rax = regs[mid_pkg::REG_RECIP_AX_BX][63:32];
            ray = regs[mid_pkg::REG_RECIP_AX_BX][31:0];
            raz = regs[mid_pkg::REG_RECIP_CX_BY][63:32];
            rby = regs[mid_pkg::REG_RECIP_CX_BY][31:0];
            rbz = regs[mid_pkg::REG_RECIP_CY_CZ][63:32];
            rcz = regs[mid_pkg::REG_RECIP_CY_CZ][31:0];
            na = round_frac(prod(rax, d.dx) + prod(ray, d.dy) + prod(raz, d.dz));
            nb = round_frac(prod(rby, d.dy) + prod(rbz, d.dz));
            nc = round_frac(prod(rcz, d.dz));
            w.dx = sat(longint'(d.dx)
                       - (longint'(ax) * na + longint'(bx) * nb + longint'(cx) * nc));
            w.dy = sat(longint'(d.dy) - (longint'(by) * nb + longint'(cy) * nc));
            w.dz = sat(longint'(d.dz) - longint'(cz) * nc);
            return w;
        endfunction

        function void note_delta(mid_pkg::vec_t d);
            expected_q.push_back(predict_wrap(d));
        endfunction

        function void check_wrap(mid_pkg::vec_t got);
            mid_pkg::vec_t exp_w;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected output beat: %0d %0d %0d", got.dx, got.dy, got.dz);
                return;
            end
            exp_w = expected_q.pop_front();
            if (got.dx !== exp_w.dx || got.dy !== exp_w.dy || got.dz !== exp_w.dz)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch x exp %0d got %0d, y exp %0d got %0d, z exp %0d got %0d",
                             exp_w.dx, got.dx, exp_w.dy, got.dy, exp_w.dz, got.dz);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    mid_pkg::len_t                   delta_x, delta_y, delta_z;
    logic                            out_valid;
    logic                            out_stall;
    mid_pkg::len_t                   wrapped_x, wrapped_y, wrapped_z;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [mid_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [mid_pkg::CFG_DATA_W-1:0]  cfg_data;

    wrap_board board = new;
    int        cycle_cnt = 0;
    int        hold_cycles;
    bit        calm = 1'b0;
    bit        hold_off_req = 1'b0;
    bit        hold_active = 1'b0;
    bit        phys_cell = 1'b0;
    longint    span = 64'sd65536;

    minimum_image_displacement uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .delta_x   (delta_x),
        .delta_y   (delta_y),
        .delta_z   (delta_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .wrapped_x (wrapped_x),
        .wrapped_y (wrapped_y),
        .wrapped_z (wrapped_z),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_cnt <= cycle_cnt + 1;

    initial
    begin
        wait (cycle_cnt == CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_wrap(mid_pkg::vec_t'({wrapped_x, wrapped_y, wrapped_z}));

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic mid_pkg::vec_t vec(mid_pkg::len_t x, mid_pkg::len_t y,
                                          mid_pkg::len_t z);
        mid_pkg::vec_t v;
        v.dx = x;
        v.dy = y;
        v.dz = z;
        return v;
    endfunction

    function automatic mid_pkg::len_t edge_val();
        case ($urandom_range(0, 4))
            0: return MAX_LEN;
            1: return MIN_LEN;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    function automatic mid_pkg::len_t rand_comp();
        if ($urandom_range(0, 9) == 0)
            return edge_val();
        return mid_pkg::len_t'($urandom);
    endfunction

    // displacement within a few cell lengths
    function automatic mid_pkg::len_t phys_comp();
        if ($urandom_range(0, 19) == 0)
            return edge_val();
        return mid_pkg::len_t'(longint'($urandom_range(0, 32'(2 * span))) - span);
    endfunction

    function automatic mid_pkg::len_t q230(real x);
        real s;
        s = x * 1073741824.0;
        if (s > 2147483647.0)
            s = 2147483647.0;
        if (s < -2147483648.0)
            s = -2147483648.0;
        return mid_pkg::len_t'($rtoi(s));
    endfunction

    // receiver side: random stalls plus one long hold on request
    initial
    begin : receiver_stall
        int n;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                hold_active = 1'b1;
                for (hold_cycles = 0; hold_cycles < LONG_HOLD; hold_cycles++)
                    @(posedge clk);
                hold_active = 1'b0;
            end
            else
            begin
                n = pick_gap();
                out_stall <= (n != 0);
                repeat ((n == 0) ? 1 : n) @(posedge clk);
            end
        end
    end

    task automatic send_delta(mid_pkg::vec_t d);
        int gap;
        in_valid <= 1'b1;
        delta_x  <= d.dx;
        delta_y  <= d.dy;
        delta_z  <= d.dz;
        do @(posedge clk); while (in_stall);
        board.note_delta(d);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering and wait for every outstanding beat
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
    endtask

    task automatic write_reg(logic [mid_pkg::CFG_IDX_W-1:0] idx,
                             logic [mid_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        board.set_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // writes the cell and its inverse, computed in floating point
    task automatic load_cell(mid_pkg::len_t ax, mid_pkg::len_t bx, mid_pkg::len_t cx,
                             mid_pkg::len_t by, mid_pkg::len_t cy, mid_pkg::len_t cz);
        real fax, fbx, fcx, fby, fcy, fcz;
        fax = $itor(ax) / 65536.0;
        fbx = $itor(bx) / 65536.0;
        fcx = $itor(cx) / 65536.0;
        fby = $itor(by) / 65536.0;
        fcy = $itor(cy) / 65536.0;
        fcz = $itor(cz) / 65536.0;
        write_reg(mid_pkg::REG_CELL_AX_BX, {ax, bx});
        write_reg(mid_pkg::REG_CELL_CX_BY, {cx, by});
        write_reg(mid_pkg::REG_CELL_CY_CZ, {cy, cz});
        write_reg(mid_pkg::REG_RECIP_AX_BX, {q230(1.0 / fax), q230(-fbx / (fax * fby))});
        write_reg(mid_pkg::REG_RECIP_CX_BY,
                  {q230((fbx * fcy - fcx * fby) / (fax * fby * fcz)), q230(1.0 / fby)});
        write_reg(mid_pkg::REG_RECIP_CY_CZ, {q230(-fcy / (fby * fcz)), q230(1.0 / fcz)});
    endtask

    task automatic random_cell();
        int     top, ax, by, cz, bx, cx, cy;
        longint widest;
        top = ($urandom_range(0, 7) == 0) ? 20000 : 64;
        ax = $urandom_range(2 << 16, top << 16);
        by = $urandom_range(2 << 16, top << 16);
        cz = $urandom_range(2 << 16, top << 16);
        bx = int'($urandom_range(0, ax)) - ax / 2;
        cx = int'($urandom_range(0, ax)) - ax / 2;
        cy = int'($urandom_range(0, by)) - by / 2;
        widest = ax;
        if (by > widest)
            widest = by;
        if (cz > widest)
            widest = cz;
        span = 4 * widest;
        if (span > 64'sd2147483647)
            span = 64'sd2147483647;
        load_cell(ax, bx, cx, by, cy, cz);
    endtask

    initial
    begin : stimulus
        mid_pkg::vec_t                 d;
        logic [mid_pkg::CFG_IDX_W-1:0] idx;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        delta_x   = '0;
        delta_y   = '0;
        delta_z   = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero cell after reset, every vector passes through
        send_delta(vec(32'sd0, 32'sd0, 32'sd0));
        send_delta(vec(MAX_LEN, MIN_LEN, 32'sd1));
        send_delta(vec(MIN_LEN, MAX_LEN, -32'sd1));
        send_delta(vec(-32'sd1, 32'sd0, MAX_LEN));

        // cube of side 8 with an exact inverse, so halves hit exactly
        drain();
        load_cell(EIGHT_LEN, 32'sd0, 32'sd0, EIGHT_LEN, 32'sd0, EIGHT_LEN);
        write_reg(REG_UNUSED_6, {$urandom, $urandom});
        write_reg(REG_UNUSED_7, {$urandom, $urandom});
        send_delta(vec(FOUR_LEN, FOUR_LEN, FOUR_LEN));
        send_delta(vec(-FOUR_LEN, -FOUR_LEN, -FOUR_LEN));
        send_delta(vec(FOUR_LEN - 32'sd1, -(FOUR_LEN - 32'sd1), 3 * FOUR_LEN));
        send_delta(vec(5 * FOUR_LEN, -5 * FOUR_LEN, 32'sd0));
        send_delta(vec(MAX_LEN, MIN_LEN, MAX_LEN));

        // extreme entries drive the results into saturation
        drain();
        write_reg(mid_pkg::REG_CELL_AX_BX, {MAX_LEN, MIN_LEN});
        write_reg(mid_pkg::REG_CELL_CX_BY, {MIN_LEN, MAX_LEN});
        write_reg(mid_pkg::REG_CELL_CY_CZ, {MAX_LEN, MAX_LEN});
        write_reg(mid_pkg::REG_RECIP_AX_BX, {MAX_LEN, MAX_LEN});
        write_reg(mid_pkg::REG_RECIP_CX_BY, {MAX_LEN, MIN_LEN});
        write_reg(mid_pkg::REG_RECIP_CY_CZ, {MIN_LEN, MIN_LEN});
        send_delta(vec(MIN_LEN, MIN_LEN, MIN_LEN));
        send_delta(vec(MAX_LEN, MAX_LEN, MAX_LEN));
        send_delta(vec(MIN_LEN, MAX_LEN, 32'sd0));
        send_delta(vec(32'sd1, -32'sd1, MAX_LEN));

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            case (p % 5)
                2:
                begin
                    phys_cell = 1'b0;
                    for (idx = mid_pkg::REG_CELL_AX_BX; idx <= mid_pkg::REG_RECIP_CY_CZ;
                         idx++)
                        write_reg(idx, {$urandom, $urandom});
                end
                3:
                begin
                    phys_cell = 1'b0;
                    for (idx = mid_pkg::REG_CELL_AX_BX; idx <= mid_pkg::REG_RECIP_CY_CZ;
                         idx++)
                        write_reg(idx, {edge_val(), edge_val()});
                end
                default:
                begin
                    phys_cell = 1'b1;
                    random_cell();
                end
            endcase
            if (p == 1)
            begin
                // receiver holds off while items keep coming, block backs up
                hold_off_req = 1'b1;
                wait (hold_active);
                calm = 1'b1;
            end
            if (p == 4)
                calm = 1'b1;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (p == 1 && i == 40)
                    calm = 1'b0;
                if (phys_cell && $urandom_range(0, 3) != 0)
                    d = vec(phys_comp(), phys_comp(), phys_comp());
                else
                    d = vec(rand_comp(), rand_comp(), rand_comp());
                send_delta(d);
            end
            calm = 1'b0;
        end

        drain();
        repeat (20) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
